/* hw/rtl/free_page_stack_allocator_unit_macros.svh */
// assertion macros for the free page stack allocator
`ifndef FREE_PAGE_STACK_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_PAGE_STACK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FPSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fpsa_pkg.sv */
// shared types, constants and helpers for the free page stack allocator
package fpsa_pkg;

	localparam int NUM_PAGES      = 32768;
	localparam int SLOT_BITS      = $clog2(NUM_PAGES);
	localparam int DEPTH_BITS     = 16;
	localparam int PAGE_BYTES     = 4096;
	localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
	localparam int ADDR_BITS      = 64;
	localparam int PAGE_NUM_BITS  = ADDR_BITS - PAGE_SHIFT;
	localparam int BASE_BITS      = 52;
	localparam int USABLE_BITS    = 16;
	localparam int COUNTER_BITS   = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 64;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

	localparam logic [BASE_BITS-1:0]   BASE_RESET   = BASE_BITS'(524288);
	localparam logic [USABLE_BITS-1:0] USABLE_RESET = USABLE_BITS'(32768);

	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE   = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_USABLE = CFG_INDEX_BITS'(1);

	localparam logic OPER_ALLOC = 1'b0;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REQ_ALLOC,
		REQ_FREE,
		REQ_BAD
	} req_kind_t;

	typedef struct packed {
		req_kind_t              kind;
		logic [SLOT_BITS-1:0]   page_idx;
	} req_t;

	typedef struct packed {
		logic                   en;
		logic [DEPTH_BITS-1:0]  pages;
	} rebuild_t;

	function automatic logic [DEPTH_BITS-1:0] cap_pages(input logic [USABLE_BITS-1:0] usable);
		logic [DEPTH_BITS-1:0] res;
		if (32'(usable) > NUM_PAGES) begin
			res = DEPTH_BITS'(NUM_PAGES);
		end else begin
			res = DEPTH_BITS'(usable);
		end
		return res;
	endfunction

endpackage

/* hw/rtl/fpsa_front.sv */
// request classifier: decodes the operation and range-checks freed addresses
module fpsa_front (
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic [fpsa_pkg::ADDR_BITS-1:0]        address,
	input  logic [fpsa_pkg::BASE_BITS-1:0]        base_page,
	input  logic [fpsa_pkg::DEPTH_BITS-1:0]       managed,
	input  logic                                  queue_full,
	output logic                                  push,
	output fpsa_pkg::req_t                        req
);
	import fpsa_pkg::*;

	logic [PAGE_NUM_BITS-1:0] page;
	logic [PAGE_NUM_BITS:0]   diff;
	logic                     aligned;
	logic                     in_range;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		page     = address[ADDR_BITS-1:PAGE_SHIFT];
		aligned  = (address[PAGE_SHIFT-1:0] == '0);
		// borrow out of the top bit means the page lies below the base
		diff     = {1'b0, page} - (PAGE_NUM_BITS+1)'(base_page);
		in_range = !diff[PAGE_NUM_BITS]
			&& (diff[PAGE_NUM_BITS-1:0] < PAGE_NUM_BITS'(managed));
		req.page_idx = diff[SLOT_BITS-1:0];
		if (operation == OPER_ALLOC) begin
			req.kind = REQ_ALLOC;
		end else if (aligned && in_range) begin
			req.kind = REQ_FREE;
		end else begin
			req.kind = REQ_BAD;
		end
	end

endmodule

/* hw/rtl/fpsa_queue.sv */
// short request queue between the classifier and the stack engine
module fpsa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpsa_pkg::req_t  push_req,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output fpsa_pkg::req_t  head
);
	import fpsa_pkg::*;

	req_t                 entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/fpsa_back.sv */
// stack engine: page stack memory, top pointer, counters and result register
module fpsa_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fpsa_pkg::rebuild_t                    rebuild,
	input  logic [fpsa_pkg::BASE_BITS-1:0]        base_page,
	input  logic                                  head_valid,
	input  fpsa_pkg::req_t                        head,
	output logic                                  head_pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            status,
	output logic [fpsa_pkg::ADDR_BITS-1:0]        page_address,
	output logic [fpsa_pkg::DEPTH_BITS-1:0]       free_pages,
	output logic [fpsa_pkg::COUNTER_BITS-1:0]     alloc_total,
	output logic [fpsa_pkg::COUNTER_BITS-1:0]     free_total,
	output logic [fpsa_pkg::COUNTER_BITS-1:0]     alloc_requests
);
	import fpsa_pkg::*;

	logic [SLOT_BITS-1:0]    stack_mem [NUM_PAGES];
	logic [SLOT_BITS-1:0]    rd_q;

	logic [DEPTH_BITS-1:0]   depth_q;
	// lowest depth since the last rebuild: slots below it were never written
	logic [DEPTH_BITS-1:0]   low_q;
	logic [COUNTER_BITS-1:0] alloc_q;
	logic [COUNTER_BITS-1:0] free_q;
	logic [COUNTER_BITS-1:0] req_q;

	logic                    valid_s2;
	status_t                 status_s2;
	logic                    has_page_s2;
	logic                    direct_s2;
	logic [SLOT_BITS-1:0]    slot_s2;

	logic                    advance;
	logic                    empty;
	logic                    full;
	logic [DEPTH_BITS-1:0]   slot_pop;
	logic                    direct;
	logic                    rd_en;
	logic                    wr_en;
	status_t                 status_d;
	logic [SLOT_BITS-1:0]    page_idx;
	logic [BASE_BITS-1:0]    page_sum;

	assign advance  = head_valid && (!valid_s2 || out_ready);
	assign head_pop = advance;

	always_comb begin
		empty    = (depth_q == '0);
		full     = (depth_q == DEPTH_BITS'(NUM_PAGES));
		slot_pop = depth_q - 1'b1;
		direct   = (slot_pop < low_q);
		rd_en    = advance && (head.kind == REQ_ALLOC) && !empty;
		wr_en    = advance && (head.kind == REQ_FREE) && !full;
		case (head.kind)
			REQ_ALLOC: status_d = empty ? ST_EMPTY : ST_OK;
			REQ_FREE:  status_d = full ? ST_FULL : ST_OK;
			REQ_BAD:   status_d = ST_BAD_ADDR;
			default:   status_d = ST_BAD_ADDR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[depth_q[SLOT_BITS-1:0]] <= head.page_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= stack_mem[slot_pop[SLOT_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2   <= status_d;
			has_page_s2 <= rd_en;
			direct_s2   <= direct;
			slot_s2     <= slot_pop[SLOT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= DEPTH_BITS'(NUM_PAGES);
			low_q    <= DEPTH_BITS'(NUM_PAGES);
			alloc_q  <= '0;
			free_q   <= '0;
			req_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (rebuild.en) begin
				depth_q <= rebuild.pages;
				low_q   <= rebuild.pages;
			end else begin
				if (advance && (head.kind == REQ_ALLOC)) begin
					req_q <= req_q + 1'b1;
				end
				if (rd_en) begin
					depth_q <= slot_pop;
					alloc_q <= alloc_q + 1'b1;
					if (direct) begin
						low_q <= slot_pop;
					end
				end
				if (wr_en) begin
					depth_q <= depth_q + 1'b1;
					free_q  <= free_q + 1'b1;
				end
			end
		end
	end

	// untouched slots still hold their own index
	assign page_idx = direct_s2 ? slot_s2 : rd_q;
	assign page_sum = base_page + BASE_BITS'(page_idx);

	assign out_valid      = valid_s2;
	assign status         = status_s2;
	assign page_address   = has_page_s2 ? ADDR_BITS'({page_sum, {PAGE_SHIFT{1'b0}}}) : '0;
	assign free_pages     = depth_q;
	assign alloc_total    = alloc_q;
	assign free_total     = free_q;
	assign alloc_requests = req_q;

endmodule

/* hw/rtl/free_page_stack_allocator_unit.sv */
// top level of the free page stack allocator
// pipeline: an accepted word is written into the request queue, then the stack engine registers its result word
// throughput: one word per cycle while out_ready stays high; each request touches at most one stack memory entry
// reset: base page 524288, 32768 usable pages, all pages free, counters zero
// the stack needs no clearing pass: a low-water mark stands in for untouched slots
`include "free_page_stack_allocator_unit_macros.svh"

module free_page_stack_allocator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fpsa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [fpsa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic [fpsa_pkg::ADDR_BITS-1:0]        address,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            status,
	output logic [fpsa_pkg::ADDR_BITS-1:0]        page_address,
	output logic [fpsa_pkg::DEPTH_BITS-1:0]       free_pages,
	output logic [fpsa_pkg::COUNTER_BITS-1:0]     alloc_total,
	output logic [fpsa_pkg::COUNTER_BITS-1:0]     free_total,
	output logic [fpsa_pkg::COUNTER_BITS-1:0]     alloc_requests
);
	import fpsa_pkg::*;

	logic [BASE_BITS-1:0]   base_q;
	logic [USABLE_BITS-1:0] usable_q;
	logic [DEPTH_BITS-1:0]  managed;
	logic [USABLE_BITS-1:0] usable_next;
	logic                   cfg_we;
	rebuild_t               rebuild;

	logic                   queue_full;
	logic                   push;
	req_t                   push_req;
	logic                   head_valid;
	req_t                   head;
	logic                   head_pop;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign managed   = cap_pages(usable_q);

	always_comb begin
		usable_next   = (cfg_index == REG_USABLE) ? cfg_data[USABLE_BITS-1:0] : usable_q;
		rebuild.en    = cfg_we && ((cfg_index == REG_BASE) || (cfg_index == REG_USABLE));
		rebuild.pages = cap_pages(usable_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RESET;
			usable_q <= USABLE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE) begin
				base_q <= cfg_data[BASE_BITS-1:0];
			end
			if (cfg_index == REG_USABLE) begin
				usable_q <= cfg_data[USABLE_BITS-1:0];
			end
		end
	end

	fpsa_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.address    (address),
		.base_page  (base_q),
		.managed    (managed),
		.queue_full (queue_full),
		.push       (push),
		.req        (push_req)
	);

	fpsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.full       (queue_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fpsa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rebuild        (rebuild),
		.base_page      (base_q),
		.head_valid     (head_valid),
		.head           (head),
		.head_pop       (head_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.page_address   (page_address),
		.free_pages     (free_pages),
		.alloc_total    (alloc_total),
		.free_total     (free_total),
		.alloc_requests (alloc_requests)
	);

	`FPSA_ASSERT_NOW(a_empty_means_no_pages, out_valid && (status == ST_EMPTY), free_pages == '0, "empty reported with pages left")
	`FPSA_ASSERT_NOW(a_full_means_all_pages, out_valid && (status == ST_FULL), free_pages == DEPTH_BITS'(NUM_PAGES), "full reported below capacity")
	`FPSA_ASSERT_NOW(a_failed_has_no_address, out_valid && (status != ST_OK), page_address == '0, "failed word carries an address")
	`FPSA_ASSERT_NEXT(a_result_follows_pop, head_pop, out_valid, "popped request produced no result")

endmodule

/* tb/sv/free_page_stack_allocator_unit_tb.sv */
// testbench for the free page stack allocator: predicts every reply word and checks it field by field
module free_page_stack_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpsa_pkg::*;

	localparam logic OPER_FREE = ~OPER_ALLOC;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LO = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HI = CFG_INDEX_BITS'(3);
	localparam int DRAIN_CYCLES    = 4;
	localparam int STALL_LIMIT     = 1000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 210;

	typedef struct {
		status_t                   status;
		logic [ADDR_BITS-1:0]      page_address;
		logic [DEPTH_BITS-1:0]     free_pages;
		logic [COUNTER_BITS-1:0]   alloc_total;
		logic [COUNTER_BITS-1:0]   free_total;
		logic [COUNTER_BITS-1:0]   alloc_requests;
	} reply_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_INDEX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic                        operation;
	logic [ADDR_BITS-1:0]        address;
	logic                        out_valid;
	logic                        out_ready;
	logic [1:0]                  status;
	logic [ADDR_BITS-1:0]        page_address;
	logic [DEPTH_BITS-1:0]       free_pages;
	logic [COUNTER_BITS-1:0]     alloc_total;
	logic [COUNTER_BITS-1:0]     free_total;
	logic [COUNTER_BITS-1:0]     alloc_requests;

	// predicted allocator state
	logic [SLOT_BITS-1:0]      page_stack [NUM_PAGES];
	logic [DEPTH_BITS-1:0]     stack_depth;
	logic [DEPTH_BITS-1:0]     managed;
	logic [BASE_BITS-1:0]      base_page;
	logic [USABLE_BITS-1:0]    region_pages;
	logic [COUNTER_BITS-1:0]   alloc_count;
	logic [COUNTER_BITS-1:0]   free_count;
	logic [COUNTER_BITS-1:0]   req_count;

	reply_t reply_q [$];
	logic   steady = 1'b0;
	int     mismatches = 0;
	int     stall_cycles = 0;
	int     requests_sent = 0;
	int     cfg_writes = 0;
	int     replies_seen = 0;
	int     status_seen [4] = '{0, 0, 0, 0};

	free_page_stack_allocator_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.address        (address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.page_address   (page_address),
		.free_pages     (free_pages),
		.alloc_total    (alloc_total),
		.free_total     (free_total),
		.alloc_requests (alloc_requests)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// every page of the region free again, highest index on top
	function automatic void restock_pages();
		for (int i = 0; i < NUM_PAGES; i++) begin
			page_stack[i] = SLOT_BITS'(i);
		end
		managed = (region_pages > NUM_PAGES) ? DEPTH_BITS'(NUM_PAGES) : region_pages;
		stack_depth = managed;
	endfunction

	function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		case (idx)
			REG_BASE: begin
				base_page = data[BASE_BITS-1:0];
				restock_pages();
			end
			REG_USABLE: begin
				region_pages = data[USABLE_BITS-1:0];
				restock_pages();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [ADDR_BITS-1:0] page_of(input int unsigned idx);
		return (ADDR_BITS'(base_page) + ADDR_BITS'(idx)) << PAGE_SHIFT;
	endfunction

	function automatic reply_t serve_request(input logic op, input logic [ADDR_BITS-1:0] addr);
		reply_t r;
		logic [ADDR_BITS-1:0] pg;
		logic [SLOT_BITS-1:0] idx;
		logic addr_ok;
		r.status = ST_OK;
		r.page_address = '0;
		if (op == OPER_ALLOC) begin
			req_count++;
			if (stack_depth == 0) begin
				r.status = ST_EMPTY;
			end else begin
				stack_depth--;
				idx = page_stack[stack_depth[SLOT_BITS-1:0]];
				r.page_address = (ADDR_BITS'(base_page) + ADDR_BITS'(idx)) << PAGE_SHIFT;
				alloc_count++;
			end
		end else begin
			pg = addr >> PAGE_SHIFT;
			addr_ok = (addr[PAGE_SHIFT-1:0] == '0) && (pg >= ADDR_BITS'(base_page))
				&& ((pg - ADDR_BITS'(base_page)) < ADDR_BITS'(managed));
			if (!addr_ok) begin
				r.status = ST_BAD_ADDR;
			end else if (stack_depth >= NUM_PAGES) begin
				r.status = ST_FULL;
			end else begin
				page_stack[stack_depth[SLOT_BITS-1:0]] = SLOT_BITS'(pg - ADDR_BITS'(base_page));
				stack_depth++;
				free_count++;
			end
		end
		r.free_pages = stack_depth;
		r.alloc_total = alloc_count;
		r.free_total = free_count;
		r.alloc_requests = req_count;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// reply checker
	always @(posedge clk) begin
		reply_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (reply_q.size() == 0) begin
				$display("%0t ns: reply word with nothing expected, status %h address %h",
					$time, status, page_address);
				mismatches++;
			end else begin
				want = reply_q.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("page_address", want.page_address, page_address);
				check_field("free_pages", 64'(want.free_pages), 64'(free_pages));
				check_field("alloc_total", 64'(want.alloc_total), 64'(alloc_total));
				check_field("free_total", 64'(want.free_total), 64'(free_total));
				check_field("alloc_requests", 64'(want.alloc_requests), 64'(alloc_requests));
				status_seen[want.status]++;
				replies_seen++;
			end
		end
	end

	// watchdog: ends the run after too long without any accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1
				|| (cfg_valid && cfg_ready) === 1'b1) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no word accepted for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready = steady || ($urandom_range(99) >= 19);
	end

	task automatic send_request(input logic op, input logic [ADDR_BITS-1:0] addr);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 19) begin
			in_valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		address = addr;
		do @(posedge clk); while (in_ready !== 1'b1);
		reply_q.push_back(serve_request(op, addr));
		requests_sent++;
	endtask

	// registers change only with the pipeline empty
	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		in_valid = 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		apply_register(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_reset_state();
		send_request(OPER_ALLOC, '0);
		send_request(OPER_FREE, page_of(NUM_PAGES - 1));
		// all pages back on the stack, so this push is refused
		send_request(OPER_FREE, page_of(NUM_PAGES - 1));
		send_request(OPER_FREE, page_of(5) + 64'd1);
		send_request(OPER_FREE, page_of(0) - 64'(PAGE_BYTES));
		send_request(OPER_FREE, page_of(NUM_PAGES));
		send_request(OPER_FREE, '1);
		send_request(OPER_FREE, '0);
		send_request(OPER_ALLOC, '1);
	endtask

	task automatic test_region_limits();
		write_register(REG_USABLE, {48'hFFFF_FFFF_FFFF, 16'h0000});
		send_request(OPER_ALLOC, '0);
		send_request(OPER_FREE, page_of(0));
		// top base page with an oversized region: addresses wrap past 2^64
		write_register(REG_BASE, '1);
		write_register(REG_USABLE, {$urandom, 16'($urandom), 16'hFFFF});
		send_request(OPER_ALLOC, '0);
		send_request(OPER_FREE, page_of(0));
		send_request(OPER_FREE, page_of(0));
		send_request(OPER_FREE, page_of(1));
		write_register(REG_BASE, '0);
		write_register(REG_USABLE, 64'd1);
		send_request(OPER_ALLOC, '0);
		send_request(OPER_ALLOC, '0);
		// a double free is accepted and stacks the page twice
		send_request(OPER_FREE, page_of(0));
		send_request(OPER_FREE, page_of(0));
		send_request(OPER_ALLOC, '0);
		send_request(OPER_ALLOC, '0);
		send_request(OPER_ALLOC, '0);
		// writes to unused indexes leave the stack alone
		write_register(REG_UNUSED_LO, {$urandom, $urandom});
		write_register(REG_UNUSED_HI, '1);
		send_request(OPER_FREE, page_of(0));
	endtask

	task automatic test_random_traffic();
		int pick;
		int unsigned idx;
		logic [63:0] junk;
		logic [63:0] rnd;
		logic [BASE_BITS-1:0] new_base;
		logic [USABLE_BITS-1:0] new_pages;
		for (int p = 0; p < PHASES; p++) begin
			rnd = {$urandom, $urandom};
			case (p % 4)
				0: new_base = '0;
				1: new_base = rnd[BASE_BITS-1:0];
				2: new_base = {BASE_BITS{1'b1}} - BASE_BITS'($urandom_range(40));
				default: new_base = BASE_RESET + BASE_BITS'($urandom_range(1000));
			endcase
			if (p == 2) begin
				new_pages = USABLE_RESET;
			end else if (p == 6) begin
				new_pages = '1;
			end else begin
				new_pages = USABLE_BITS'($urandom_range(48, 1));
			end
			write_register(REG_BASE, {12'($urandom), new_base});
			write_register(REG_USABLE, {$urandom, 16'($urandom), new_pages});
			steady = (p == 4);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				junk = {$urandom, $urandom};
				idx = (managed == 0) ? 0 : $urandom_range(int'(managed) - 1);
				if (pick < 45) begin
					send_request(OPER_ALLOC, junk);
				end else if (pick < 80) begin
					send_request(OPER_FREE, page_of(idx));
				end else begin
					case (pick % 4)
						0: send_request(OPER_FREE, page_of(idx) | 64'($urandom_range(PAGE_BYTES - 1, 1)));
						1: send_request(OPER_FREE, page_of(0) - 64'(PAGE_BYTES) * $urandom_range(3, 1));
						2: send_request(OPER_FREE, page_of(int'(managed) + $urandom_range(3)));
						default: send_request(OPER_FREE, junk);
					endcase
				end
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 1'b0;
		address = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		out_ready = 1'b0;
		base_page = BASE_RESET;
		region_pages = USABLE_RESET;
		alloc_count = '0;
		free_count = '0;
		req_count = '0;
		restock_pages();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_region_limits();
		test_random_traffic();

		@(negedge clk);
		in_valid = 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d register writes, %0d reply words checked",
			requests_sent, cfg_writes, replies_seen);
		$display("replies: %0d ok, %0d out of pages, %0d bad address, %0d stack full",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BAD_ADDR],
			status_seen[ST_FULL]);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
